[src/polar_pose_velocity_control_macros.svh]
// ---------------------------------------------------------------------------
// Polar pose velocity control: assertion macros
// Shared concurrent assertion forms for the pose controller.
// ---------------------------------------------------------------------------
`ifndef POLAR_POSE_VELOCITY_CONTROL_MACROS_SVH
`define POLAR_POSE_VELOCITY_CONTROL_MACROS_SVH

// same-cycle implication
`define PPVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define PPVC_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

[src/ppvc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Polar pose velocity control package
// Widths, fixed-point constants, CORDIC angle table and register indexes.
// ---------------------------------------------------------------------------
package ppvc_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;   // at most 24, the length of the angle table
  localparam int LIMIT_WIDTH   = 15;
  localparam int CFG_IDX_W     = 3;

  localparam int GUARD_SHIFT = 8;                 // dx, dy scaled by 2^8
  localparam int DIFF_W      = DATA_WIDTH + 1;    // exact pose differences
  localparam int CW          = 28;                // CORDIC x / y datapath
  localparam int ZW          = 28;                // CORDIC angle, Q.24 radians
  localparam int BW          = ZW - 12;           // bearing, Q4.12
  localparam int AW          = DIFF_W + 1;        // alpha
  localparam int BTW         = DIFF_W + 2;        // beta
  localparam int INV_W       = 31;
  localparam int PW          = CW + INV_W;        // rho product
  localparam int RHO_SHIFT   = 38;
  localparam int RHO_W       = 18;
  localparam int PA_W        = DATA_WIDTH + AW;
  localparam int PB_W        = DATA_WIDTH + BTW;
  localparam int WS_W        = PB_W + 1;
  localparam int W_W         = WS_W - 8;
  localparam int VP_W        = DATA_WIDTH + RHO_W;
  localparam int V_W         = VP_W - 8;

  // start accepted to done strobe
  localparam int LATENCY = CORDIC_STAGES + 5;

  localparam logic signed [ZW-1:0]    HALF_PI_Q24  = 28'sd26353589;
  localparam logic signed [INV_W-1:0] INV_GAIN_Q30 = 31'sd652032874;

  localparam logic [23:0] ATAN_Q24 [24] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123,   24'd131069,  24'd65536,   24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,     24'd256,     24'd128,
    24'd64,       24'd32,      24'd16,      24'd8,       24'd4,       24'd2
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_DISTANCE    = 3'd0,
    REG_GAIN_HEADING     = 3'd1,
    REG_GAIN_ORIENTATION = 3'd2,
    REG_LIMIT_LINEAR     = 3'd3,
    REG_LIMIT_ANGULAR    = 3'd4
  } cfg_reg_e;

  localparam logic signed [DATA_WIDTH-1:0]  GAIN_DISTANCE_RST    = 16'sd768;
  localparam logic signed [DATA_WIDTH-1:0]  GAIN_HEADING_RST     = 16'sd2048;
  localparam logic signed [DATA_WIDTH-1:0]  GAIN_ORIENTATION_RST = -16'sd384;
  localparam logic [LIMIT_WIDTH-1:0]        LIMIT_LINEAR_RST     = 15'd2048;
  localparam logic [LIMIT_WIDTH-1:0]        LIMIT_ANGULAR_RST    = 15'd8192;

endpackage

[src/polar_pose_velocity_control.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Polar pose velocity control
// Unicycle pose controller: pose error to clamped linear / angular velocity.
// ---------------------------------------------------------------------------
// A transaction is taken at every rising edge with start_i high; busy_o is
// always low, so one pose may enter in every cycle. Each result appears on
// the result ports for exactly one cycle with done_o high, once its pose has
// passed one input stage, one stage per CORDIC micro-rotation (16) and four
// stages of multiply, round and clamp (stages A to D). The
// receiver cannot stall, so results leave in order and the pipeline never
// holds. The gain and limit registers are written through cfg_valid_i /
// cfg_ready_o (always ready); write them only while no pose is in flight.
// No clearing pass is needed after reset.
`include "polar_pose_velocity_control_macros.svh"

module polar_pose_velocity_control (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // pose channel
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [ppvc_pkg::DATA_WIDTH-1:0] cur_x_i,
  input  logic signed [ppvc_pkg::DATA_WIDTH-1:0] cur_y_i,
  input  logic signed [ppvc_pkg::DATA_WIDTH-1:0] cur_yaw_i,
  input  logic signed [ppvc_pkg::DATA_WIDTH-1:0] goal_x_i,
  input  logic signed [ppvc_pkg::DATA_WIDTH-1:0] goal_y_i,
  input  logic signed [ppvc_pkg::DATA_WIDTH-1:0] goal_yaw_i,
  // result channel
  output logic                                   done_o,
  output logic signed [ppvc_pkg::DATA_WIDTH-1:0] lin_vel_o,
  output logic signed [ppvc_pkg::DATA_WIDTH-1:0] ang_vel_o,
  output logic                                   lin_clamped_o,
  output logic                                   ang_clamped_o,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ppvc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ppvc_pkg::DATA_WIDTH-1:0]        cfg_data_i
);
  import ppvc_pkg::*;

  localparam int N = CORDIC_STAGES;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] gain_distance_q, gain_heading_q, gain_orientation_q;
  logic [LIMIT_WIDTH-1:0]       limit_linear_q, limit_angular_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_distance_q    <= GAIN_DISTANCE_RST;
      gain_heading_q     <= GAIN_HEADING_RST;
      gain_orientation_q <= GAIN_ORIENTATION_RST;
      limit_linear_q     <= LIMIT_LINEAR_RST;
      limit_angular_q    <= LIMIT_ANGULAR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GAIN_DISTANCE:    gain_distance_q    <= $signed(cfg_data_i);
        REG_GAIN_HEADING:     gain_heading_q     <= $signed(cfg_data_i);
        REG_GAIN_ORIENTATION: gain_orientation_q <= $signed(cfg_data_i);
        REG_LIMIT_LINEAR:     limit_linear_q     <= cfg_data_i[LIMIT_WIDTH-1:0];
        REG_LIMIT_ANGULAR:    limit_angular_q    <= cfg_data_i[LIMIT_WIDTH-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Valid shift line: input stage, CORDIC stages, then stages A to D
  // -------------------------------------------------------------------------
  logic       accept;
  logic [N:0] vld_q;
  logic       vld_a_q, vld_b_q, vld_c_q, done_q;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_q   <= {vld_q[N-1:0], accept};
      vld_a_q <= vld_q[N];
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      done_q  <= vld_c_q;
    end
  end

  // -------------------------------------------------------------------------
  // Input stage: pose differences, guard scaling and quadrant pre-rotation
  // -------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dx, dy, dth;
  logic signed [CW-1:0]     xg, yg, x0, y0;
  logic signed [ZW-1:0]     z0;

  assign dx  = DIFF_W'(goal_x_i)   - DIFF_W'(cur_x_i);
  assign dy  = DIFF_W'(goal_y_i)   - DIFF_W'(cur_y_i);
  assign dth = DIFF_W'(goal_yaw_i) - DIFF_W'(cur_yaw_i);
  assign xg  = {{(CW-DIFF_W-GUARD_SHIFT){dx[DIFF_W-1]}}, dx, {GUARD_SHIFT{1'b0}}};
  assign yg  = {{(CW-DIFF_W-GUARD_SHIFT){dy[DIFF_W-1]}}, dy, {GUARD_SHIFT{1'b0}}};

  // rotate a left half-plane vector by a quarter turn into the right half
  always_comb begin
    x0 = xg;
    y0 = yg;
    z0 = '0;
    if (xg[CW-1]) begin
      if (!yg[CW-1]) begin
        x0 = yg;
        y0 = -xg;
        z0 = HALF_PI_Q24;
      end else begin
        x0 = -yg;
        y0 = xg;
        z0 = -HALF_PI_Q24;
      end
    end
  end

  logic signed [CW-1:0]     cx_q  [N+1];
  logic signed [CW-1:0]     cy_q  [N+1];
  logic signed [ZW-1:0]     cz_q  [N+1];
  logic signed [DIFF_W-1:0] dth_q [N+1];
  logic                     zero_q[N+1];

  always_ff @(posedge clk_i) begin
    cx_q[0]   <= x0;
    cy_q[0]   <= y0;
    cz_q[0]   <= z0;
    dth_q[0]  <= dth;
    zero_q[0] <= (dx == '0) && (dy == '0);
  end

  // -------------------------------------------------------------------------
  // Vectoring CORDIC: one micro-rotation per register stage
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    logic                 up;

    assign xs  = cx_q[i] >>> i;
    assign ys  = cy_q[i] >>> i;
    assign ang = $signed({{(ZW-24){1'b0}}, ATAN_Q24[i]});
    assign up  = !cy_q[i][CW-1];

    always_ff @(posedge clk_i) begin
      cx_q[i+1]   <= up ? cx_q[i] + ys : cx_q[i] - ys;
      cy_q[i+1]   <= up ? cy_q[i] - xs : cy_q[i] + xs;
      cz_q[i+1]   <= up ? cz_q[i] + ang : cz_q[i] - ang;
      dth_q[i+1]  <= dth_q[i];
      zero_q[i+1] <= zero_q[i];
    end
  end

  // -------------------------------------------------------------------------
  // Stage A: bearing, alpha, beta; gain-correct the CORDIC magnitude
  // -------------------------------------------------------------------------
  logic signed [ZW-1:0]  z_rnd;
  logic signed [BW-1:0]  bearing;
  logic signed [AW-1:0]  alpha;
  logic signed [BTW-1:0] beta;
  logic signed [CW-1:0]  x_mag;

  assign z_rnd   = cz_q[N] + ZW'(2048);
  // a zero vector has neither distance nor bearing
  assign bearing = zero_q[N] ? '0 : z_rnd[ZW-1:12];
  assign x_mag   = zero_q[N] ? '0 : cx_q[N];
  assign alpha   = AW'(bearing) - AW'(dth_q[N]);
  assign beta    = BTW'(dth_q[N]) - BTW'(alpha);

  logic signed [AW-1:0]  a_alpha_q;
  logic signed [BTW-1:0] a_beta_q;
  logic signed [PW-1:0]  a_prod_q;

  always_ff @(posedge clk_i) begin
    a_alpha_q <= alpha;
    a_beta_q  <= beta;
    a_prod_q  <= PW'(x_mag) * PW'(INV_GAIN_Q30);
  end

  // -------------------------------------------------------------------------
  // Stage B: round rho; heading and orientation products
  // -------------------------------------------------------------------------
  logic signed [PW-1:0] prod_rnd;

  assign prod_rnd = a_prod_q + {{(PW-RHO_SHIFT){1'b0}}, 1'b1, {(RHO_SHIFT-1){1'b0}}};

  logic signed [RHO_W-1:0] b_rho_q;
  logic signed [PA_W-1:0]  b_pa_q;
  logic signed [PB_W-1:0]  b_pb_q;

  always_ff @(posedge clk_i) begin
    b_rho_q <= prod_rnd[RHO_SHIFT+RHO_W-1:RHO_SHIFT];
    b_pa_q  <= PA_W'(gain_heading_q) * PA_W'(a_alpha_q);
    b_pb_q  <= PB_W'(gain_orientation_q) * PB_W'(a_beta_q);
  end

  // -------------------------------------------------------------------------
  // Stage C: sum and round the angular command; linear product
  // -------------------------------------------------------------------------
  logic signed [WS_W-1:0] w_sum;

  assign w_sum = WS_W'(b_pa_q) + WS_W'(b_pb_q) + WS_W'(128);

  logic signed [W_W-1:0]  c_w_q;
  logic signed [VP_W-1:0] c_vp_q;

  always_ff @(posedge clk_i) begin
    c_w_q  <= w_sum[WS_W-1:8];
    c_vp_q <= VP_W'(gain_distance_q) * VP_W'(b_rho_q);
  end

  // -------------------------------------------------------------------------
  // Stage D: round the linear command, clamp both to their limits
  // -------------------------------------------------------------------------
  logic signed [VP_W-1:0] v_sum;
  logic signed [V_W-1:0]  v_raw, v_lim;
  logic signed [W_W-1:0]  w_lim;
  logic signed [DATA_WIDTH-1:0] lin_d, ang_d;
  logic                   lin_hit, ang_hit;

  assign v_sum = c_vp_q + VP_W'(128);
  assign v_raw = v_sum[VP_W-1:8];
  assign v_lim = $signed({{(V_W-LIMIT_WIDTH){1'b0}}, limit_linear_q});
  assign w_lim = $signed({{(W_W-LIMIT_WIDTH){1'b0}}, limit_angular_q});

  always_comb begin
    lin_hit = 1'b1;
    if (v_raw > v_lim) begin
      lin_d = v_lim[DATA_WIDTH-1:0];
    end else if (v_raw < -v_lim) begin
      lin_d = DATA_WIDTH'(-v_lim);
    end else begin
      lin_hit = 1'b0;
      lin_d   = v_raw[DATA_WIDTH-1:0];
    end
    ang_hit = 1'b1;
    if (c_w_q > w_lim) begin
      ang_d = w_lim[DATA_WIDTH-1:0];
    end else if (c_w_q < -w_lim) begin
      ang_d = DATA_WIDTH'(-w_lim);
    end else begin
      ang_hit = 1'b0;
      ang_d   = c_w_q[DATA_WIDTH-1:0];
    end
  end

  logic signed [DATA_WIDTH-1:0] lin_vel_q, ang_vel_q;
  logic                         lin_clamped_q, ang_clamped_q;

  always_ff @(posedge clk_i) begin
    lin_vel_q     <= lin_d;
    ang_vel_q     <= ang_d;
    lin_clamped_q <= lin_hit;
    ang_clamped_q <= ang_hit;
  end

  assign done_o        = done_q;
  assign lin_vel_o     = lin_vel_q;
  assign ang_vel_o     = ang_vel_q;
  assign lin_clamped_o = lin_clamped_q;
  assign ang_clamped_o = ang_clamped_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] lin_lim_s, ang_lim_s;

  assign lin_lim_s = $signed({1'b0, limit_linear_q});
  assign ang_lim_s = $signed({1'b0, limit_angular_q});

  `PPVC_ASSERT_DLY(a_latency, clk_i, rst_ni, accept, LATENCY, done_o, "result strobe missing")
  `PPVC_ASSERT_DLY(a_zero_vec, clk_i, rst_ni, accept && (dx == '0) && (dy == '0), LATENCY, (lin_vel_o == '0) && !lin_clamped_o, "zero distance gave linear command")
  `PPVC_ASSERT_IMP(a_lin_clamp, clk_i, rst_ni, done_o && lin_clamped_o, (lin_vel_o == $past(lin_lim_s)) || (lin_vel_o == -$past(lin_lim_s)), "linear clamp off limit")
  `PPVC_ASSERT_IMP(a_ang_clamp, clk_i, rst_ni, done_o && ang_clamped_o, (ang_vel_o == $past(ang_lim_s)) || (ang_vel_o == -$past(ang_lim_s)), "angular clamp off limit")

endmodule
